// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cwd_pkg.sv -----
// Types, codes and helpers of the card whitelist door controller.
// No dependencies; used by the controller, table and checker files through cwd_pkg:: names.
package cwd_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int UID_BYTES_MAX     = 10;
    localparam logic [3:0] UID_LEN_MAX = 4'(UID_BYTES_MAX);

    localparam int CFG_W = 8;
    localparam logic [CFG_W-1:0] OPEN_HOLD_RESET = 8'd2;
    localparam logic [CFG_W-1:0] MSG_HOLD_RESET  = 8'd3;

    // register indexes
    localparam logic CFG_OPEN_HOLD = 1'b0;
    localparam logic CFG_MSG_HOLD  = 1'b1;

    // operations
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REMOVE  = 2'd1;
    localparam logic [1:0] OP_PRESENT = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // status codes
    localparam logic [3:0] ST_ADDED     = 4'd0;
    localparam logic [3:0] ST_DUPLICATE = 4'd1;
    localparam logic [3:0] ST_TOO_LONG  = 4'd2;
    localparam logic [3:0] ST_FULL      = 4'd3;
    localparam logic [3:0] ST_REMOVED   = 4'd4;
    localparam logic [3:0] ST_NOT_FOUND = 4'd5;
    localparam logic [3:0] ST_GRANTED   = 4'd6;
    localparam logic [3:0] ST_DENIED    = 4'd7;
    localparam logic [3:0] ST_NONE      = 4'd8;

    // door phases
    localparam logic [1:0] PH_CLOSED  = 2'd0;
    localparam logic [1:0] PH_OPENING = 2'd1;
    localparam logic [1:0] PH_OPEN    = 2'd2;
    localparam logic [1:0] PH_CLOSING = 2'd3;

    // display modes / actions
    localparam logic [1:0] DISP_NONE   = 2'd0;
    localparam logic [1:0] DISP_NAME   = 2'd1;
    localparam logic [1:0] DISP_DENIED = 2'd2;
    localparam logic [1:0] DISP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] uid_low;
        logic [15:0] uid_high;
        logic [3:0]  uid_length;
        logic [63:0] holder_tag;
    } t_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  door_phase;
        logic [1:0]  display_action;
        logic [63:0] display_tag;
        logic        led_on;
    } t_result;

    // one table entry, also the search key
    typedef struct packed {
        logic [3:0]  len;
        logic [63:0] lo;
        logic [15:0] hi;
        logic [63:0] tag;
    } t_tbl_entry;

    typedef struct packed {
        logic scan;   // start a walk over the table
        logic wr;     // write entry and set valid
        logic clr;    // drop valid
    } t_tbl_cmd;

    typedef struct packed {
        logic done;   // walk finished, flags below are final
        logic found;  // a valid entry matched the key
        logic free;   // an invalid slot exists
    } t_tbl_stat;

    // keep UID bytes 1..8 below the length, byte 1 in the top bits
    function automatic logic [63:0] mask_low(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (len > 4'(b)) begin
                m[63-8*b -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic logic [15:0] mask_high(input logic [3:0] len);
        return {{8{len >= 4'd9}}, {8{len >= 4'd10}}};
    endfunction

endpackage

// ----- src/card_whitelist_door_controller.sv -----
// Card whitelist door controller, top level.
// Depends on cwd_pkg and cwd_table.
//
// A transfer in is taken at a clock edge with start high and busy low. Add,
// remove and card presentation walk the whole table memory through its one
// read port, one entry a cycle; a one-second tick does not touch the table.
// Exactly one result per item appears on o_result for a single cycle with
// o_valid high, in the cycle busy drops; the receiver cannot stall it, so it
// must take the transfer then. A new item may be started in that same cycle.
// The hold registers (index 0 open hold, index 1 message hold, in seconds)
// are written through i_cfg_we and take effect at once; write them only while
// the block is idle. No clearing pass is needed after reset: the valid flags
// are cleared by reset.
module card_whitelist_door_controller #(
    parameter int TABLE_ENTRIES = cwd_pkg::TABLE_ENTRIES_DEF,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  cwd_pkg::t_item            i_item,
    output logic                      o_valid,
    output cwd_pkg::t_result          o_result,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [cwd_pkg::CFG_W-1:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] r_op;
    cwd_pkg::t_tbl_entry r_key;
    logic accept;

    // configuration
    logic [cwd_pkg::CFG_W-1:0] r_open_hold;
    logic [cwd_pkg::CFG_W-1:0] r_msg_hold;

    // timers, all wrap at 2^32
    logic [31:0] r_now, r_last_grant, n_last_grant;
    logic [31:0] r_open_since, n_open_since;
    logic [31:0] r_msg_since, n_msg_since;
    logic [31:0] grant_age, open_age, msg_age;

    // door and display machines
    logic [1:0]  r_door, n_door;
    logic [1:0]  r_disp, n_disp;
    logic [1:0]  r_prev_disp, n_prev_disp;
    logic [63:0] r_shown_tag, n_shown_tag;
    logic        r_shown_v, n_shown_v;
    logic [63:0] r_shown_last, n_shown_last;   // tag last put on the display
    logic        r_shown_last_v, n_shown_last_v;
    logic        r_granted, n_granted;
    logic        r_led, n_led;

    cwd_pkg::t_result r_res, n_res;
    logic             r_valid;

    // table interface
    cwd_pkg::t_tbl_cmd  tbl_cmd;
    cwd_pkg::t_tbl_stat tbl_stat;
    logic [IW-1:0]      tbl_idx;
    logic [IW-1:0]      found_idx;
    logic [IW-1:0]      free_idx;
    logic [63:0]        found_tag;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    cwd_table #(
        .NUM_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (tbl_cmd),
        .i_idx       (tbl_idx),
        .i_key       (r_key),
        .o_stat      (tbl_stat),
        .o_found_idx (found_idx),
        .o_found_tag (found_tag),
        .o_free_idx  (free_idx)
    );

    // r_now already holds the incremented time when a tick finishes
    assign grant_age = r_now - r_last_grant;
    assign open_age  = r_now - r_open_since;
    assign msg_age   = r_now - r_msg_since;

    always_comb begin
        n_last_grant   = r_last_grant;
        n_open_since   = r_open_since;
        n_msg_since    = r_msg_since;
        n_door         = r_door;
        n_disp         = r_disp;
        n_prev_disp    = r_prev_disp;
        n_shown_tag    = r_shown_tag;
        n_shown_v      = r_shown_v;
        n_shown_last   = r_shown_last;
        n_shown_last_v = r_shown_last_v;
        n_granted      = r_granted;
        n_led          = r_led;
        n_res          = '0;
        n_res.status   = cwd_pkg::ST_NONE;

        tbl_cmd.scan = accept && (i_item.operation != cwd_pkg::OP_TICK);
        tbl_cmd.wr   = 1'b0;
        tbl_cmd.clr  = 1'b0;
        tbl_idx      = free_idx;

        if (r_state == S_FIN) begin
            case (r_op)
                cwd_pkg::OP_ADD: begin
                    if (r_key.len > cwd_pkg::UID_LEN_MAX) begin
                        n_res.status = cwd_pkg::ST_TOO_LONG;
                    end else if (tbl_stat.found) begin
                        n_res.status = cwd_pkg::ST_DUPLICATE;
                    end else if (tbl_stat.free) begin
                        n_res.status = cwd_pkg::ST_ADDED;
                        tbl_cmd.wr   = 1'b1;
                    end else begin
                        n_res.status = cwd_pkg::ST_FULL;
                    end
                end
                cwd_pkg::OP_REMOVE: begin
                    // stored lengths never exceed the limit, so an overlong
                    // key simply never matches
                    if (tbl_stat.found) begin
                        n_res.status = cwd_pkg::ST_REMOVED;
                        tbl_cmd.clr  = 1'b1;
                        tbl_idx      = found_idx;
                    end else begin
                        n_res.status = cwd_pkg::ST_NOT_FOUND;
                    end
                end
                cwd_pkg::OP_PRESENT: begin
                    if (tbl_stat.found) begin
                        n_res.status = cwd_pkg::ST_GRANTED;
                        n_door       = cwd_pkg::PH_OPENING;
                        n_disp       = r_granted ? cwd_pkg::DISP_NAME : cwd_pkg::DISP_NONE;
                        n_granted    = 1'b1;
                        n_last_grant = r_now;
                        // new holder: show it
                        if (!(r_shown_v && (r_shown_tag == found_tag))) begin
                            n_disp      = cwd_pkg::DISP_NAME;
                            n_shown_tag = found_tag;
                            n_shown_v   = 1'b1;
                        end
                    end else begin
                        n_res.status = cwd_pkg::ST_DENIED;
                        n_granted    = 1'b0;
                        n_door       = cwd_pkg::PH_CLOSING;
                        n_disp       = cwd_pkg::DISP_DENIED;
                    end
                end
                default: begin
                    // one-second tick
                    // grant expiry drops the held tag, repeats on every tick
                    if ((grant_age > {24'd0, r_msg_hold}) && r_granted) begin
                        n_shown_v   = 1'b0;
                        n_shown_tag = '0;
                        n_disp      = cwd_pkg::DISP_CLEAR;
                    end

                    case (r_door)
                        cwd_pkg::PH_OPENING: begin
                            n_open_since = r_now;
                            n_door       = cwd_pkg::PH_OPEN;
                        end
                        cwd_pkg::PH_OPEN: begin
                            if (open_age > {24'd0, r_open_hold}) begin
                                n_door = cwd_pkg::PH_CLOSING;
                            end
                        end
                        cwd_pkg::PH_CLOSING: begin
                            n_door = cwd_pkg::PH_CLOSED;
                        end
                        default: begin
                            n_led = 1'b0;
                        end
                    endcase

                    case (n_disp)
                        cwd_pkg::DISP_NAME: begin
                            if (r_prev_disp != cwd_pkg::DISP_NAME) begin
                                n_led = !n_led;
                            end
                            if ((r_prev_disp == cwd_pkg::DISP_NAME) && r_shown_last_v &&
                                n_shown_v && (r_shown_last == n_shown_tag)) begin
                                // same holder already on the display
                                n_disp = cwd_pkg::DISP_CLEAR;
                            end else begin
                                n_res.display_action = cwd_pkg::DISP_NAME;
                                n_res.display_tag    = n_shown_v ? n_shown_tag : 64'd0;
                                if (n_shown_v) begin
                                    n_shown_last   = n_shown_tag;
                                    n_shown_last_v = 1'b1;
                                end
                                n_msg_since = r_now;
                                n_disp      = cwd_pkg::DISP_CLEAR;
                                n_prev_disp = cwd_pkg::DISP_NAME;
                            end
                        end
                        cwd_pkg::DISP_DENIED: begin
                            if (r_prev_disp == cwd_pkg::DISP_DENIED) begin
                                n_disp = cwd_pkg::DISP_CLEAR;
                            end else begin
                                n_res.display_action = cwd_pkg::DISP_DENIED;
                                n_msg_since = r_now;
                                n_disp      = cwd_pkg::DISP_CLEAR;
                                n_prev_disp = cwd_pkg::DISP_DENIED;
                            end
                        end
                        cwd_pkg::DISP_CLEAR: begin
                            if (msg_age > {24'd0, r_msg_hold}) begin
                                n_res.display_action = cwd_pkg::DISP_CLEAR;
                                n_disp      = cwd_pkg::DISP_NONE;
                                n_prev_disp = cwd_pkg::DISP_CLEAR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            endcase
        end

        n_res.door_phase = n_door;
        n_res.led_on     = n_led;
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_op           <= cwd_pkg::OP_ADD;
            r_valid        <= 1'b0;
            r_now          <= '0;
            r_last_grant   <= '0;
            r_open_since   <= '0;
            r_msg_since    <= '0;
            r_door         <= cwd_pkg::PH_CLOSED;
            r_disp         <= cwd_pkg::DISP_NONE;
            r_prev_disp    <= cwd_pkg::DISP_NONE;
            r_shown_tag    <= '0;
            r_shown_v      <= 1'b0;
            r_shown_last   <= '0;
            r_shown_last_v <= 1'b0;
            r_granted      <= 1'b0;
            r_led          <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op <= i_item.operation;
                        if (i_item.operation == cwd_pkg::OP_TICK) begin
                            r_now   <= r_now + 32'd1;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (tbl_stat.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state        <= S_IDLE;
                    r_valid        <= 1'b1;
                    r_last_grant   <= n_last_grant;
                    r_open_since   <= n_open_since;
                    r_msg_since    <= n_msg_since;
                    r_door         <= n_door;
                    r_disp         <= n_disp;
                    r_prev_disp    <= n_prev_disp;
                    r_shown_tag    <= n_shown_tag;
                    r_shown_v      <= n_shown_v;
                    r_shown_last   <= n_shown_last;
                    r_shown_last_v <= n_shown_last_v;
                    r_granted      <= n_granted;
                    r_led          <= n_led;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload: key masked to its length, result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key.len <= i_item.uid_length;
            r_key.lo  <= i_item.uid_low & cwd_pkg::mask_low(i_item.uid_length);
            r_key.hi  <= i_item.uid_high & cwd_pkg::mask_high(i_item.uid_length);
            r_key.tag <= i_item.holder_tag;
        end
        if (r_state == S_FIN) begin
            r_res <= n_res;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_hold <= cwd_pkg::OPEN_HOLD_RESET;
            r_msg_hold  <= cwd_pkg::MSG_HOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cwd_pkg::CFG_OPEN_HOLD: r_open_hold <= i_cfg_data;
                cwd_pkg::CFG_MSG_HOLD:  r_msg_hold  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// ----- src/cwd_table.sv -----
// Whitelist table: entry memory, valid flags and the match/free-slot walk.
// Depends on cwd_pkg.
module cwd_table #(
    parameter int NUM_ENTRIES = cwd_pkg::TABLE_ENTRIES_DEF,
    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cwd_pkg::t_tbl_cmd    i_cmd,
    input  logic [IW-1:0]        i_idx,
    input  cwd_pkg::t_tbl_entry  i_key,
    output cwd_pkg::t_tbl_stat   o_stat,
    output logic [IW-1:0]        o_found_idx,
    output logic [63:0]          o_found_tag,
    output logic [IW-1:0]        o_free_idx
);

    localparam logic [IW-1:0] LAST = IW'(NUM_ENTRIES - 1);

    cwd_pkg::t_tbl_entry r_mem [NUM_ENTRIES];
    cwd_pkg::t_tbl_entry r_rd;
    logic [NUM_ENTRIES-1:0] r_valid;

    logic          r_scan;
    logic [IW-1:0] r_addr;
    logic          r_chk;
    logic [IW-1:0] r_chk_idx;
    logic          r_done;
    logic          r_found;
    logic [IW-1:0] r_found_idx;
    logic [63:0]   r_found_tag;
    logic          r_free;
    logic [IW-1:0] r_free_idx;
    logic          hit;

    // entry memory, one read and one write port
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_addr];
        if (i_cmd.wr) begin
            r_mem[i_idx] <= i_key;
        end
    end

    assign hit = r_valid[r_chk_idx] && (r_rd.len == i_key.len) &&
                 (r_rd.lo == i_key.lo) && (r_rd.hi == i_key.hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_scan      <= 1'b0;
            r_addr      <= '0;
            r_chk       <= 1'b0;
            r_chk_idx   <= '0;
            r_done      <= 1'b0;
            r_found     <= 1'b0;
            r_found_idx <= '0;
            r_found_tag <= '0;
            r_free      <= 1'b0;
            r_free_idx  <= '0;
        end else begin
            r_chk     <= r_scan;
            r_chk_idx <= r_addr;
            r_done    <= r_chk && (r_chk_idx == LAST);

            if (i_cmd.scan) begin
                r_scan  <= 1'b1;
                r_addr  <= '0;
                r_found <= 1'b0;
                r_free  <= 1'b0;
            end else if (r_scan) begin
                if (r_addr == LAST) begin
                    r_scan <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end

            // compare stage, data of r_chk_idx is in r_rd now
            if (r_chk) begin
                if (hit && !r_found) begin
                    r_found     <= 1'b1;
                    r_found_idx <= r_chk_idx;
                    r_found_tag <= r_rd.tag;
                end
                if (!r_valid[r_chk_idx] && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_chk_idx;
                end
            end

            if (i_cmd.wr) begin
                r_valid[i_idx] <= 1'b1;
            end else if (i_cmd.clr) begin
                r_valid[i_idx] <= 1'b0;
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.found = r_found;
    assign o_stat.free  = r_free;
    assign o_found_idx  = r_found_idx;
    assign o_found_tag  = r_found_tag;
    assign o_free_idx   = r_free_idx;

endmodule

// ----- src/cwd_checker.sv -----
// Port-level checks of the card whitelist door controller, bound to the top.
// Depends on cwd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cwd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_valid,
    input cwd_pkg::t_result o_result
);

    logic took_item;
    logic grant_out;
    logic deny_out;
    logic non_tick_out;
    logic ph_opening;
    logic ph_closing;
    logic no_action;

    assign took_item    = start && !busy;
    assign grant_out    = o_valid && (o_result.status == cwd_pkg::ST_GRANTED);
    assign deny_out     = o_valid && (o_result.status == cwd_pkg::ST_DENIED);
    assign non_tick_out = o_valid && (o_result.status != cwd_pkg::ST_NONE);
    assign ph_opening   = (o_result.door_phase == cwd_pkg::PH_OPENING);
    assign ph_closing   = (o_result.door_phase == cwd_pkg::PH_CLOSING);
    assign no_action    = (o_result.display_action == cwd_pkg::DISP_NONE);

    `CWD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, took_item, busy, "busy not raised")

    `CWD_ASSERT_NOW(a_grant_opens, i_clk, i_rst_n, grant_out, ph_opening, "grant w/o opening")

    `CWD_ASSERT_NOW(a_deny_closes, i_clk, i_rst_n, deny_out, ph_closing, "denial w/o closing")

    `CWD_ASSERT_NOW(a_disp_on_tick, i_clk, i_rst_n, non_tick_out, no_action, "action off tick")

endmodule

bind card_whitelist_door_controller cwd_checker u_cwd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
